### design/piecewise_linear_interpolator_unit_defines.svh
// Assertion macros shared by the interpolator modules.
// No dependencies; included by pli_ctrl and pli_datapath.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; used by pli_ctrl, pli_datapath and the top level.
package pli_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// one quotient bit per step over the full 64-bit product
	localparam int DIV_STEPS = 64;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_ZERO_WIDTH = 2'd2,
		ST_SAT        = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RES_EMPTY   = 2'd0,
		RES_F1_OK   = 2'd1,
		RES_F1_ZW   = 2'd2,
		RES_CALC    = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     descending;
		logic     wr_en;
		logic     load_t;
		logic     cap_last;
		logic     scan_step;
		logic     cap_seg1;
		logic     cap_seg2;
		logic     diff;
		logic     absval;
		logic     mul;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic first_hit;
		logic last_hit;
		logic bracket;
		logic zero_width;
	} dp_stat_t;

endpackage

### design/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator: breakpoint table plus
// interpolation with linear extrapolation. Depends on pli_pkg, pli_ctrl, pli_datapath.
//
//  channel  | handshake               | word
//  ---------+-------------------------+------------------------------------------
//  input    | start && !busy          | command, point_index, point_x/y, query_x
//  result   | done (one-cycle strobe) | result_value, status
//  config   | cfg_valid && cfg_ready  | cfg_index, cfg_data
//
// A write word stores its breakpoint at the accepting edge and leaves busy low.
// A query holds busy through the last-point read, table search, segment reads and the
// difference, magnitude, multiply, divide and final-add steps; the table search reads
// one breakpoint per cycle from the single-port memory and the restoring divider
// retires one quotient bit per cycle. Empty, single-point and zero-width cases answer
// early. done fires the cycle after the last step with busy already low; the receiver
// cannot stall. Reset clears the controller and configuration; table contents are
// undefined. cfg_ready is always high; write configuration only while idle.
// Values are signed fixed point; the fraction width cancels in the quotient,
// so the datapath is the same for any fraction width.
module piecewise_linear_interpolator_unit #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input word
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic [5:0]                       point_index,
	input  logic signed [31:0]               point_x,
	input  logic signed [31:0]               point_y,
	input  logic signed [31:0]               query_x,
	// result word
	output logic                             done,
	output logic signed [31:0]               result_value,
	output logic [1:0]                       status,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pli_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pli_pkg::*;

	dp_cmd_t                  cmd;
	dp_stat_t                 stat;
	logic [$clog2(DEPTH)-1:0] rd_addr;

	// sequencer: owns configuration, search indexes and divide count
	pli_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.command   (command),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// table memory, compares, multiply, divide and saturation
	pli_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.query_x      (query_x),
		.stat         (stat),
		.result_value (result_value),
		.status       (status)
	);

endmodule

### design/pli_datapath.sv
// Datapath: breakpoint memory, search compares, multiplier, restoring divider
// and result saturation. Depends on pli_pkg and the assertion macro header.
`include "piecewise_linear_interpolator_unit_defines.svh"

module pli_datapath #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pli_pkg::dp_cmd_t            cmd,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	input  logic [5:0]                  point_index,
	input  logic signed [31:0]          point_x,
	input  logic signed [31:0]          point_y,
	input  logic signed [31:0]          query_x,
	output pli_pkg::dp_stat_t           stat,
	output logic signed [31:0]          result_value,
	output logic [1:0]                  status
);
	import pli_pkg::*;

	localparam int AW = $clog2(DEPTH);

	// {x, y} per breakpoint
	logic [63:0] mem [DEPTH];
	logic [63:0] rd_data_q;

	logic signed [31:0] t_q, prev_q, x1_q, f1_q, x2_q, f2_q;
	logic signed [32:0] d_f_q, d_t_q, d_x_q;
	logic [31:0] mag_a_q, mag_b_q, den_q, rem_q;
	logic [63:0] quo_q;
	logic        neg_q, zero_q, last_hit_q;
	logic signed [31:0] result_q;
	status_t     status_q;

	logic signed [31:0] rd_x, rd_y;
	logic        slot_ok;
	logic [63:0] prod;
	logic [32:0] rem_sh;
	logic [33:0] sub;
	logic        q_sat;
	logic signed [34:0] sum;
	logic        sum_fits;
	logic signed [31:0] calc_val;
	status_t     calc_st;

	assign rd_x    = $signed(rd_data_q[63:32]);
	assign rd_y    = $signed(rd_data_q[31:0]);
	assign slot_ok = (32'(point_index) < DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && slot_ok) begin
			mem[AW'(point_index)] <= {point_x, point_y};
		end
		rd_data_q <= mem[rd_addr];
	end

	// search compares against the word just read
	always_comb begin
		if (!cmd.descending) begin
			stat.first_hit = (t_q <= rd_x);
			stat.bracket   = (t_q >= prev_q) && (t_q < rd_x);
		end else begin
			stat.first_hit = (t_q >= rd_x);
			stat.bracket   = (t_q <= prev_q) && (t_q > rd_x);
		end
		stat.last_hit   = last_hit_q;
		stat.zero_width = zero_q;
	end

	assign prod   = mag_a_q * mag_b_q;
	assign rem_sh = {rem_q, quo_q[63]};
	assign sub    = {1'b0, rem_sh} - {2'b00, den_q};

	// final add and clamp
	always_comb begin
		q_sat    = |quo_q[63:33];
		sum      = neg_q ? ({{3{f1_q[31]}}, f1_q} - {2'b00, quo_q[32:0]})
		                 : ({{3{f1_q[31]}}, f1_q} + {2'b00, quo_q[32:0]});
		sum_fits = (sum[34:31] == 4'b0000) || (sum[34:31] == 4'b1111);
		if (q_sat) begin
			calc_val = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
			calc_st  = ST_SAT;
		end else if (!sum_fits) begin
			calc_val = sum[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			calc_st  = ST_SAT;
		end else begin
			calc_val = sum[31:0];
			calc_st  = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_t) begin
			t_q <= query_x;
		end
		if (cmd.cap_last) begin
			last_hit_q <= cmd.descending ? (t_q <= rd_x) : (t_q >= rd_x);
		end
		if (cmd.scan_step) begin
			prev_q <= rd_x;
		end
		if (cmd.cap_seg1) begin
			x1_q <= rd_x;
			f1_q <= rd_y;
		end
		if (cmd.cap_seg2) begin
			x2_q <= rd_x;
			f2_q <= rd_y;
		end
		if (cmd.diff) begin
			d_f_q  <= {f1_q[31], f1_q} - {f2_q[31], f2_q};
			d_t_q  <= {t_q[31], t_q} - {x1_q[31], x1_q};
			d_x_q  <= {x1_q[31], x1_q} - {x2_q[31], x2_q};
			zero_q <= (x1_q == x2_q);
		end
		if (cmd.absval) begin
			mag_a_q <= d_f_q[32] ? 32'(-d_f_q) : d_f_q[31:0];
			mag_b_q <= d_t_q[32] ? 32'(-d_t_q) : d_t_q[31:0];
			den_q   <= d_x_q[32] ? 32'(-d_x_q) : d_x_q[31:0];
			neg_q   <= d_f_q[32] ^ d_t_q[32] ^ d_x_q[32];
		end
		if (cmd.mul) begin
			quo_q <= prod;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!sub[33]) begin
				rem_q <= sub[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				RES_EMPTY: begin
					result_q <= '0;
					status_q <= ST_EMPTY;
				end
				RES_F1_OK: begin
					result_q <= f1_q;
					status_q <= ST_OK;
				end
				RES_F1_ZW: begin
					result_q <= f1_q;
					status_q <= ST_ZERO_WIDTH;
				end
				RES_CALC: begin
					result_q <= calc_val;
					status_q <= calc_st;
				end
				default: begin
					result_q <= '0;
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign result_value = result_q;
	assign status       = status_q;

	`PLI_ASSERT_NEXT(a_sat_flag, clk, arst_n, cmd.res_load && cmd.res_sel == RES_CALC && q_sat, status == ST_SAT, "saturated quotient did not flag")
	`PLI_ASSERT_NEXT(a_empty_zero, clk, arst_n, cmd.res_load && cmd.res_sel == RES_EMPTY, result_value == '0 && status == ST_EMPTY, "empty table result wrong")
	`PLI_ASSERT_NEXT(a_rem_bound, clk, arst_n, cmd.div_step, rem_q < den_q, "divider remainder not below divisor")

endmodule

### design/pli_ctrl.sv
// Controller: configuration registers, query sequencer and done strobe.
// Depends on pli_pkg and the assertion macro header.
`include "piecewise_linear_interpolator_unit_defines.svh"

module pli_ctrl #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	output logic                               done,
	input  logic                               command,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pli_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pli_pkg::dp_stat_t                  stat,
	output pli_pkg::dp_cmd_t                   cmd,
	output logic [$clog2(DEPTH)-1:0]           rd_addr
);
	import pli_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LAST, S_FIRST, S_SCAN, S_SEG1, S_SEG2, S_SEG3,
		S_DIFF, S_ABS, S_MUL, S_DIV, S_FIN
	} state_t;

	state_t                  state_q;
	logic                    desc_q;
	logic [CFG_DATA_W-1:0]   count_q;
	logic [AW-1:0]           j_q, k_q;
	logic [DIV_CW-1:0]       cnt_q;
	logic                    done_q;

	logic [NW-1:0] n, n_m1, n_m2;
	logic          accept, single;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign accept    = start && !busy;

	// clamp the programmed count to the table depth
	assign n      = (32'(count_q) > DEPTH) ? NW'(DEPTH) : NW'(count_q);
	assign n_m1   = n - NW'(1);
	assign n_m2   = n - NW'(2);
	assign single = (n == NW'(1));

	always_comb begin
		cmd            = '0;
		cmd.descending = desc_q;
		rd_addr        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_WRITE) begin
					cmd.wr_en = 1'b1;
				end else if (accept) begin
					cmd.load_t = 1'b1;
					if (n == '0) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_EMPTY;
					end
				end
			end
			S_LAST:  rd_addr = AW'(n_m1);
			S_FIRST: cmd.cap_last = 1'b1;
			S_SCAN: begin
				rd_addr       = j_q + AW'(1);
				cmd.scan_step = 1'b1;
			end
			S_SEG1: rd_addr = k_q;
			S_SEG2: begin
				rd_addr      = k_q + AW'(1);
				cmd.cap_seg1 = 1'b1;
			end
			S_SEG3: begin
				cmd.cap_seg2 = 1'b1;
				if (single) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_F1_OK;
				end
			end
			S_DIFF: cmd.diff = 1'b1;
			S_ABS: begin
				if (stat.zero_width) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_F1_ZW;
				end else begin
					cmd.absval = 1'b1;
				end
			end
			S_MUL: cmd.mul = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_CALC;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			desc_q  <= 1'b0;
			count_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DESCENDING:  desc_q  <= cfg_data[0];
					REG_POINT_COUNT: count_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && command == CMD_QUERY) begin
						if (single) begin
							k_q     <= '0;
							state_q <= S_SEG1;
						end else if (n != '0) begin
							state_q <= S_LAST;
						end
					end
				end
				S_LAST: state_q <= S_FIRST;
				S_FIRST: begin
					j_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (j_q == '0) begin
						if (stat.first_hit) begin
							k_q     <= '0;
							state_q <= S_SEG1;
						end else if (stat.last_hit) begin
							k_q     <= AW'(n_m2);
							state_q <= S_SEG1;
						end else begin
							j_q <= j_q + AW'(1);
						end
					end else if (stat.bracket) begin
						k_q     <= j_q - AW'(1);
						state_q <= S_SEG1;
					end else if (NW'(j_q) == n_m1) begin
						// nothing brackets the target: fall back to segment 0
						k_q     <= '0;
						state_q <= S_SEG1;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				S_SEG1: state_q <= S_SEG2;
				S_SEG2: state_q <= S_SEG3;
				S_SEG3: state_q <= single ? S_IDLE : S_DIFF;
				S_DIFF: state_q <= S_ABS;
				S_ABS:  state_q <= stat.zero_width ? S_IDLE : S_MUL;
				S_MUL: begin
					cnt_q   <= DIV_CW'(DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - DIV_CW'(1);
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PLI_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy, "done strobe while still busy")
	`PLI_ASSERT_NEXT(a_write_silent, clk, arst_n, accept && command == CMD_WRITE, !done, "write word produced a result")
	`PLI_ASSERT_NEXT(a_query_starts, clk, arst_n, accept && command == CMD_QUERY, busy || done, "query word neither started nor answered")

endmodule
